FILE: rtl/triangle_pair_overlap_2d_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the triangle pair overlap block.
// ---------------------------------------------------------------------------
`ifndef TRIANGLE_PAIR_OVERLAP_2D_DEFINES_SVH
`define TRIANGLE_PAIR_OVERLAP_2D_DEFINES_SVH
`ifndef SYNTH
`define TPO_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("assertion failed");
`define TPO_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("assertion failed");
`else
`define TPO_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define TPO_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: rtl/tpo_pkg.sv
// ---------------------------------------------------------------------------
// Triangle pair overlap package
// Shared widths and types.
// ---------------------------------------------------------------------------
package tpo_pkg;
	localparam int COORD_BITS = 20;
	localparam int FRAC_BITS = 16;
	localparam int DIFF_BITS = COORD_BITS + 1;
	localparam int PROD_BITS = 2 * DIFF_BITS;
	localparam int CROSS_BITS = PROD_BITS + 1;
	localparam int LIM_BITS = CROSS_BITS + FRAC_BITS + 2;
	localparam int TOL_BITS = 16;
	localparam int EPS_BITS = 12;
	localparam logic [1:0] REG_VMT = 2'd0;
	localparam logic [1:0] REG_PTOL = 2'd1;
	localparam logic [1:0] REG_EPS = 2'd2;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic signed [DIFF_BITS-1:0] diff_t;
	typedef logic signed [PROD_BITS-1:0] prod_t;
	typedef logic signed [CROSS_BITS-1:0] cross_t;
	typedef logic signed [LIM_BITS-1:0] lim_t;

	typedef struct packed {
		logic [TOL_BITS-1:0] vmt;
		logic [TOL_BITS-1:0] ptol;
		logic [EPS_BITS-1:0] eps;
	} cfg_t;
endpackage

FILE: rtl/tpo_cross.sv
// ---------------------------------------------------------------------------
// Cross product unit
// Two-stage signed cross product px*qy - py*qx of coordinate differences.
// ---------------------------------------------------------------------------
module tpo_cross import tpo_pkg::*; (
	input  logic   clk,
	input  logic   en,
	input  diff_t  px,
	input  diff_t  py,
	input  diff_t  qx,
	input  diff_t  qy,
	output cross_t res
);
	prod_t m0_q, m1_q;
	cross_t r_q;

	always_ff @(posedge clk) begin
		if (en) begin
			m0_q <= prod_t'(px) * prod_t'(qy);
			m1_q <= prod_t'(py) * prod_t'(qx);
			r_q <= cross_t'(m0_q) - cross_t'(m1_q);
		end
	end

	assign res = r_q;
endmodule

FILE: rtl/triangle_pair_overlap_2d.sv
// ---------------------------------------------------------------------------
// Triangle pair overlap
// Reports shared edge, raw overlap and counted overlap for two triangles.
// ---------------------------------------------------------------------------
// Six register stages lie between an input transfer and output valid.
// Throughput: one pair per cycle; the pipeline advances when its last stage is free.
// Stages: differences, products, cross sums, sign normalisation, margin limits,
// compares with flag reduction.
// Reset clears valid bits and restores the register reset values.
module triangle_pair_overlap_2d import tpo_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  coord_t     a0_x, a0_y, a1_x, a1_y, a2_x, a2_y,
	input  coord_t     b0_x, b0_y, b1_x, b1_y, b2_x, b2_y,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       shares_edge,
	output logic       raw_overlap,
	output logic       counted_overlap,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [31:0] cfg_data
);
`include "triangle_pair_overlap_2d_defines.svh"
	cfg_t cfg_q;
	logic en;
	logic [5:0] v_q;
	coord_t ax [3], ay [3], bx [3], by [3];

	assign cfg_ready = 1'b1;
	assign en = !v_q[5] || out_ready;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.vmt <= TOL_BITS'(43);
			cfg_q.ptol <= TOL_BITS'(43);
			cfg_q.eps <= EPS_BITS'(7);
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_VMT: cfg_q.vmt <= cfg_data[TOL_BITS-1:0];
				REG_PTOL: cfg_q.ptol <= cfg_data[TOL_BITS-1:0];
				REG_EPS: cfg_q.eps <= cfg_data[EPS_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_q <= '0;
		else if (en) v_q <= {v_q[4:0], in_valid};
	end

	assign ax[0] = a0_x; assign ay[0] = a0_y;
	assign ax[1] = a1_x; assign ay[1] = a1_y;
	assign ax[2] = a2_x; assign ay[2] = a2_y;
	assign bx[0] = b0_x; assign by[0] = b0_y;
	assign bx[1] = b1_x; assign by[1] = b1_y;
	assign bx[2] = b2_x; assign by[2] = b2_y;

	// Stage 1: all coordinate differences. Cross product slots:
	// 0..8 A vertex in B, 9..17 B vertex in A, 18..44 edge pairs (c, tn, un).
	localparam int NC = 45;
	diff_t px_s1 [NC], py_s1 [NC], qx_s1 [NC], qy_s1 [NC];
	diff_t dvx_s1 [9], dvy_s1 [9];
	cross_t cr [NC];

	function automatic diff_t df(coord_t a, coord_t b);
		return diff_t'(a) - diff_t'(b);
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				for (int k = 0; k < 3; k++) begin
					int m;
					m = (k + 1) % 3;
					// Edge k of the containment test is (p - v_m) x (v_k - v_m).
					px_s1[3*i+k] <= df(ax[i], bx[m]);
					py_s1[3*i+k] <= df(ay[i], by[m]);
					qx_s1[3*i+k] <= df(bx[k], bx[m]);
					qy_s1[3*i+k] <= df(by[k], by[m]);
					px_s1[9+3*i+k] <= df(bx[i], ax[m]);
					py_s1[9+3*i+k] <= df(by[i], ay[m]);
					qx_s1[9+3*i+k] <= df(ax[k], ax[m]);
					qy_s1[9+3*i+k] <= df(ay[k], ay[m]);
					dvx_s1[3*i+k] <= df(ax[i], bx[k]);
					dvy_s1[3*i+k] <= df(ay[i], by[k]);
					// edge pair (i,k): d1 = A edge, d2 = B edge, d = q1 - p1
					px_s1[18+3*(3*i+k)] <= df(ax[(i+1)%3], ax[i]);
					py_s1[18+3*(3*i+k)] <= df(ay[(i+1)%3], ay[i]);
					qx_s1[18+3*(3*i+k)] <= df(bx[m], bx[k]);
					qy_s1[18+3*(3*i+k)] <= df(by[m], by[k]);
					px_s1[19+3*(3*i+k)] <= df(bx[k], ax[i]);
					py_s1[19+3*(3*i+k)] <= df(by[k], ay[i]);
					qx_s1[19+3*(3*i+k)] <= df(bx[m], bx[k]);
					qy_s1[19+3*(3*i+k)] <= df(by[m], by[k]);
					px_s1[20+3*(3*i+k)] <= df(bx[k], ax[i]);
					py_s1[20+3*(3*i+k)] <= df(by[k], ay[i]);
					qx_s1[20+3*(3*i+k)] <= df(ax[(i+1)%3], ax[i]);
					qy_s1[20+3*(3*i+k)] <= df(ay[(i+1)%3], ay[i]);
				end
			end
		end
	end

	// Stages 2 and 3: cross products.
	for (genvar g = 0; g < NC; g++) begin : g_cross
		tpo_cross u_cross (
			.clk(clk), .en(en),
			.px(px_s1[g]), .py(py_s1[g]), .qx(qx_s1[g]), .qy(qy_s1[g]),
			.res(cr[g])
		);
	end

	// Vertex distances run alongside: squares in stage 2, sum in stage 3.
	prod_t sqx_s2 [9], sqy_s2 [9];
	logic [PROD_BITS:0] d2_s3 [9];
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 9; i++) begin
				sqx_s2[i] <= prod_t'(dvx_s1[i]) * prod_t'(dvx_s1[i]);
				sqy_s2[i] <= prod_t'(dvy_s1[i]) * prod_t'(dvy_s1[i]);
				d2_s3[i] <= {1'b0, sqx_s2[i]} + {1'b0, sqy_s2[i]};
			end
		end
	end

	// Stage 4: containment flags, vertex match, sign-normalised crossing terms.
	logic raw_in_s4, shares_s4;
	logic par_s4 [9];
	cross_t c_s4 [9], tn_s4 [9], un_s4 [9];
	logic raw_in_c, shares_c;
	always_comb begin
		int cnt;
		logic hit, ng, ps;
		raw_in_c = 1'b0;
		cnt = 0;
		for (int i = 0; i < 6; i++) begin
			ng = 1'b0; ps = 1'b0;
			for (int k = 0; k < 3; k++) begin
				if (cr[3*i+k] < 0) ng = 1'b1;
				else if (cr[3*i+k] != 0) ps = 1'b1;
			end
			if (!(ng && ps)) raw_in_c = 1'b1;
		end
		for (int i = 0; i < 3; i++) begin
			hit = 1'b0;
			for (int k = 0; k < 3; k++)
				if (d2_s3[3*i+k] < (PROD_BITS+1)'(cfg_q.vmt)) hit = 1'b1;
			if (hit) cnt = cnt + 1;
		end
		shares_c = cnt >= 2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			raw_in_s4 <= raw_in_c;
			shares_s4 <= shares_c;
			for (int p = 0; p < 9; p++) begin
				if (cr[18+3*p] < 0) begin
					c_s4[p] <= -cr[18+3*p];
					tn_s4[p] <= -cr[19+3*p];
					un_s4[p] <= -cr[20+3*p];
					par_s4[p] <= (-cr[18+3*p]) <= cross_t'({1'b0, cfg_q.ptol});
				end else begin
					c_s4[p] <= cr[18+3*p];
					tn_s4[p] <= cr[19+3*p];
					un_s4[p] <= cr[20+3*p];
					par_s4[p] <= cr[18+3*p] <= cross_t'({1'b0, cfg_q.ptol});
				end
			end
		end
	end

	// Stage 5: margin limits. The upper limit is c times the whole segment less the margin.
	lim_t lo_s5 [9], hi_s5 [9], ts_s5 [9], us_s5 [9];
	logic par_s5 [9];
	logic raw_in_s5, shares_s5;
	always_ff @(posedge clk) begin
		if (en) begin
			raw_in_s5 <= raw_in_s4;
			shares_s5 <= shares_s4;
			for (int p = 0; p < 9; p++) begin
				par_s5[p] <= par_s4[p];
				lo_s5[p] <= lim_t'(c_s4[p]) * lim_t'({1'b0, cfg_q.eps});
				hi_s5[p] <= lim_t'(c_s4[p]) * lim_t'((FRAC_BITS+1)'(1 << FRAC_BITS)
					- (FRAC_BITS+1)'(cfg_q.eps));
				ts_s5[p] <= lim_t'(tn_s4[p]) <<< FRAC_BITS;
				us_s5[p] <= lim_t'(un_s4[p]) <<< FRAC_BITS;
			end
		end
	end

	// Stage 6: compares and flag reduction into the output register.
	always_ff @(posedge clk) begin
		if (en) begin
			logic any;
			any = raw_in_s5;
			for (int p = 0; p < 9; p++)
				if (!par_s5[p] && (lo_s5[p] < ts_s5[p]) && (ts_s5[p] < hi_s5[p])
						&& (lo_s5[p] < us_s5[p]) && (us_s5[p] < hi_s5[p]))
					any = 1'b1;
			raw_overlap <= any;
			shares_edge <= shares_s5;
			counted_overlap <= any && !shares_s5;
		end
	end

	assign out_valid = v_q[5];

	`TPO_ASSERT_NEXT(a_hold, clk, arst_n, out_valid && !out_ready, out_valid)
	`TPO_ASSERT_IMP(a_cnt, clk, arst_n, out_valid, !(counted_overlap && shares_edge))
	`TPO_ASSERT_IMP(a_raw, clk, arst_n, out_valid && counted_overlap, raw_overlap)
endmodule
